// File: design/tkm_pkg.sv
`timescale 1ns / 1ps

package tkm_pkg;

  localparam int VALUE_W        = 31;
  localparam int COORD_W        = 10;
  localparam int RANK_W         = 4;
  localparam int KEEP_W         = 5;
  localparam int RESULT_CAP     = 16;
  localparam int MAX_KEEP_DEF   = 16;
  localparam int COORD_BITS_DEF = 10;
  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_READOUT = 2'b10
  } state_e;

  // Control shared by every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift_up;
    logic clear;
  } cell_ctrl_t;

endpackage

// File: design/tkm_sample_if.sv
`timescale 1ns / 1ps

interface tkm_sample_if import tkm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] sample_value;
  logic [COORD_W-1:0] sample_row;
  logic [COORD_W-1:0] sample_col;
  logic               last_sample;

  modport source (output valid, sample_value, sample_row, sample_col, last_sample,
                  input ready);
  modport sink   (input valid, sample_value, sample_row, sample_col, last_sample,
                  output ready);
endinterface

// File: design/tkm_result_if.sv
`timescale 1ns / 1ps

interface tkm_result_if import tkm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RANK_W-1:0]  rank;
  logic [VALUE_W-1:0] top_value;
  logic [COORD_W-1:0] top_row;
  logic [COORD_W-1:0] top_col;
  logic               last_of_run;

  modport source (output valid, rank, top_value, top_row, top_col, last_of_run,
                  input ready);
  modport sink   (input valid, rank, top_value, top_row, top_col, last_of_run,
                  output ready);
endinterface

// File: design/tkm_cfg_if.sv
`timescale 1ns / 1ps

interface tkm_cfg_if import tkm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEEP_W-1:0] keep_count;

  modport source (output valid, keep_count, input ready);
  modport sink   (input valid, keep_count, output ready);
endinterface

// File: design/tkm_cell.sv
`timescale 1ns / 1ps

module tkm_cell import tkm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic                  active_i,
  input  logic [VALUE_W-1:0]    smp_value_i,
  input  logic [COORD_BITS-1:0] smp_row_i,
  input  logic [COORD_BITS-1:0] smp_col_i,
  input  logic                  prev_gt_i,
  input  logic [VALUE_W-1:0]    prev_value_i,
  input  logic [COORD_BITS-1:0] prev_row_i,
  input  logic [COORD_BITS-1:0] prev_col_i,
  input  logic [VALUE_W-1:0]    next_value_i,
  input  logic [COORD_BITS-1:0] next_row_i,
  input  logic [COORD_BITS-1:0] next_col_i,
  output logic                  gt_o,
  output logic [VALUE_W-1:0]    value_o,
  output logic [COORD_BITS-1:0] row_o,
  output logic [COORD_BITS-1:0] col_o
);

  logic [VALUE_W-1:0]    value_d, value_q;
  logic [COORD_BITS-1:0] row_d, row_q;
  logic [COORD_BITS-1:0] col_d, col_q;

  // List stays sorted, so the strict compare is monotone along the active cells
  assign gt_o = active_i && (smp_value_i > value_q);

  always_comb begin
    value_d = value_q;
    row_d   = row_q;
    col_d   = col_q;
    if (ctrl_i.clear) begin
      value_d = '0;
      row_d   = '0;
      col_d   = '0;
    end else if (ctrl_i.shift_up) begin
      value_d = next_value_i;
      row_d   = next_row_i;
      col_d   = next_col_i;
    end else if (ctrl_i.insert && gt_o) begin
      if (prev_gt_i) begin
        // insertion point lies above: take the neighbor's entry
        value_d = prev_value_i;
        row_d   = prev_row_i;
        col_d   = prev_col_i;
      end else begin
        value_d = smp_value_i;
        row_d   = smp_row_i;
        col_d   = smp_col_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      value_q <= value_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  assign value_o = value_q;
  assign row_o   = row_q;
  assign col_o   = col_q;

endmodule

// File: design/top_k_max_with_coordinates.sv
`timescale 1ns / 1ps

// Streaming top-k selector: keeps the keep_count largest sample values of a
// scan, with their coordinates, sorted in descending order in a chain of
// compare-and-shift cells. An ordinary sample is taken every cycle, since each
// cell compares against its own entry in parallel. A sample marked
// last is inserted in its cycle; then the block reads out min(k, 16) result
// beats, where k is keep_count with zero read as one and capped at MAX_KEEP,
// one per cycle while the sink is ready, by shifting the chain toward cell 0,
// and takes no sample during that readout. The list is cleared on the final
// result beat; after reset it is already clear.
module top_k_max_with_coordinates import tkm_pkg::*; #(
  parameter int MAX_KEEP   = MAX_KEEP_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tkm_cfg_if.sink      cfg_i,
  tkm_sample_if.sink   sample_i,
  tkm_result_if.source result_o
);

  localparam int KW = $clog2(MAX_KEEP + 1);

  state_e            state_d, state_q;
  logic [KEEP_W-1:0] keep_count_q;
  logic [RANK_W-1:0] rank_d, rank_q;
  logic [RANK_W-1:0] last_rank_d, last_rank_q;
  logic [KW-1:0]     k_eff;
  logic [RANK_W-1:0] k_last_rank;
  cell_ctrl_t        ctrl;
  logic              in_beat, out_beat, run_end;

  logic [VALUE_W-1:0]    val_w [MAX_KEEP];
  logic [COORD_BITS-1:0] row_w [MAX_KEEP];
  logic [COORD_BITS-1:0] col_w [MAX_KEEP];
  logic                  gt_w  [MAX_KEEP];
  logic [COORD_BITS-1:0] smp_row, smp_col;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q <= KEEP_RESET;
    end else if (cfg_i.valid) begin
      keep_count_q <= cfg_i.keep_count;
    end
  end

  // Zero reads as one, large counts saturate at the chain length
  always_comb begin
    if (keep_count_q == '0) begin
      k_eff = KW'(1);
    end else if (int'(keep_count_q) > MAX_KEEP) begin
      k_eff = KW'(MAX_KEEP);
    end else begin
      k_eff = KW'(keep_count_q);
    end
    if (int'(k_eff) >= RESULT_CAP) begin
      k_last_rank = RANK_W'(RESULT_CAP - 1);
    end else begin
      k_last_rank = RANK_W'(int'(k_eff) - 1);
    end
  end

  assign sample_i.ready = (state_q == ST_COLLECT);
  assign in_beat        = sample_i.valid && sample_i.ready;
  assign result_o.valid = (state_q == ST_READOUT);
  assign out_beat       = result_o.valid && result_o.ready;
  assign run_end        = (rank_q == last_rank_q);

  always_comb begin
    state_d       = state_q;
    rank_d        = rank_q;
    last_rank_d   = last_rank_q;
    ctrl.insert   = 1'b0;
    ctrl.shift_up = 1'b0;
    ctrl.clear    = 1'b0;
    unique case (state_q)
      ST_COLLECT: begin
        if (in_beat) begin
          ctrl.insert = 1'b1;
          if (sample_i.last_sample) begin
            state_d     = ST_READOUT;
            rank_d      = '0;
            last_rank_d = k_last_rank;
          end
        end
      end
      ST_READOUT: begin
        if (out_beat) begin
          if (run_end) begin
            ctrl.clear = 1'b1;
            state_d    = ST_COLLECT;
          end else begin
            ctrl.shift_up = 1'b1;
            rank_d        = rank_q + RANK_W'(1);
          end
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      rank_q      <= '0;
      last_rank_q <= '0;
    end else begin
      state_q     <= state_d;
      rank_q      <= rank_d;
      last_rank_q <= last_rank_d;
    end
  end

  assign smp_row = COORD_BITS'(sample_i.sample_row);
  assign smp_col = COORD_BITS'(sample_i.sample_col);

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic                  prev_gt;
    logic [VALUE_W-1:0]    prev_value, next_value;
    logic [COORD_BITS-1:0] prev_row, prev_col, next_row, next_col;

    if (i == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_value = '0;
      assign prev_row   = '0;
      assign prev_col   = '0;
    end else begin : g_body
      assign prev_gt    = gt_w[i-1];
      assign prev_value = val_w[i-1];
      assign prev_row   = row_w[i-1];
      assign prev_col   = col_w[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign next_value = '0;
      assign next_row   = '0;
      assign next_col   = '0;
    end else begin : g_mid
      assign next_value = val_w[i+1];
      assign next_row   = row_w[i+1];
      assign next_col   = col_w[i+1];
    end

    tkm_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .active_i     (i < int'(k_eff)),
      .smp_value_i  (sample_i.sample_value),
      .smp_row_i    (smp_row),
      .smp_col_i    (smp_col),
      .prev_gt_i    (prev_gt),
      .prev_value_i (prev_value),
      .prev_row_i   (prev_row),
      .prev_col_i   (prev_col),
      .next_value_i (next_value),
      .next_row_i   (next_row),
      .next_col_i   (next_col),
      .gt_o         (gt_w[i]),
      .value_o      (val_w[i]),
      .row_o        (row_w[i]),
      .col_o        (col_w[i])
    );
  end

  assign result_o.rank        = rank_q;
  assign result_o.top_value   = val_w[0];
  assign result_o.top_row     = COORD_W'(row_w[0]);
  assign result_o.top_col     = COORD_W'(col_w[0]);
  assign result_o.last_of_run = run_end;

endmodule

// File: design/tkm_chk.sv
`timescale 1ns / 1ps

module tkm_chk import tkm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_last_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [RANK_W-1:0]  out_rank_i,
  input logic [VALUE_W-1:0] out_value_i,
  input logic               out_last_i
);

  logic in_beat, out_beat;
  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("sample taken during readout");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_last_i |=> out_valid_i && (out_rank_i == '0))
    else $error("readout did not start at rank zero");

  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && !out_last_i |=> out_valid_i &&
      (out_rank_i == $past(out_rank_i) + RANK_W'(1)))
    else $error("rank did not advance by one");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && out_last_i |=> !out_valid_i && in_ready_i)
    else $error("readout continued past its final beat");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_rank_i) &&
      $stable(out_value_i))
    else $error("stalled result beat changed");

endmodule

bind top_k_max_with_coordinates tkm_chk u_tkm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .in_last_i   (sample_i.last_sample),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_rank_i  (result_o.rank),
  .out_value_i (result_o.top_value),
  .out_last_i  (result_o.last_of_run)
);
